// ----- sv/atacmd_pkg.sv -----
package atacmd_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_PRI_CMD_BASE  = 3'd0;
    localparam logic [2:0] CFG_PRI_CTRL_BASE = 3'd1;
    localparam logic [2:0] CFG_SEC_CMD_BASE  = 3'd2;
    localparam logic [2:0] CFG_SEC_CTRL_BASE = 3'd3;
    localparam logic [2:0] CFG_DRIVE_TABLE   = 3'd4;

    localparam logic [15:0] PRI_CMD_BASE_RST  = 16'h01F0;
    localparam logic [15:0] PRI_CTRL_BASE_RST = 16'h03F6;
    localparam logic [15:0] SEC_CMD_BASE_RST  = 16'h0170;
    localparam logic [15:0] SEC_CTRL_BASE_RST = 16'h0376;
    localparam logic [11:0] DRIVE_TABLE_RST   = 12'h000;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // chs split: lba / 63 by reciprocal, ceil(2^34 / 63)
    localparam logic [28:0] CHS_RECIP       = 29'd272696337;
    localparam int          CHS_RECIP_SHIFT = 34;
    localparam logic [6:0]  CHS_SPT         = 7'd63;

    localparam logic [7:0] CTRL_HOB      = 8'h80;
    localparam logic [7:0] CTRL_NIEN     = 8'h02;
    localparam logic [7:0] DEVSEL_CHS    = 8'hA0;
    localparam logic [7:0] DEVSEL_LBA    = 8'hE0;
    localparam logic [7:0] CMD_READ      = 8'h20;
    localparam logic [7:0] CMD_READ_EXT  = 8'h24;
    localparam logic [7:0] CMD_WRITE     = 8'h30;
    localparam logic [7:0] CMD_WRITE_EXT = 8'h34;

    // task file register offsets from the command block base
    localparam logic [15:0] REG_COUNT   = 16'd2;
    localparam logic [15:0] REG_LBA_LO  = 16'd3;
    localparam logic [15:0] REG_LBA_MID = 16'd4;
    localparam logic [15:0] REG_LBA_HI  = 16'd5;
    localparam logic [15:0] REG_DEVSEL  = 16'd6;
    localparam logic [15:0] REG_COMMAND = 16'd7;
    localparam logic [15:0] CTRL_OFFSET = 16'd2;

    typedef struct packed {
        logic [15:0] pri_cmd_base;
        logic [15:0] pri_ctrl_base;
        logic [15:0] sec_cmd_base;
        logic [15:0] sec_ctrl_base;
        logic [11:0] drive_table;
    } cfg_t;

    // one resolved command, front to back
    typedef struct packed {
        logic        ext;
        logic [15:0] cmd_base;
        logic [15:0] ctrl_addr;
        logic [7:0]  devsel;
        logic [7:0]  count;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [7:0]  opcode;
    } cmd_rec_t;

    typedef enum logic [4:0] {
        STEP_CTRL,
        STEP_DEVSEL,
        STEP_HOB_CNT_SET,
        STEP_HOB_CNT,
        STEP_HOB_CNT_CLR,
        STEP_HOB_LO_SET,
        STEP_HOB_LO,
        STEP_HOB_LO_CLR,
        STEP_HOB_MID_SET,
        STEP_HOB_MID,
        STEP_HOB_MID_CLR,
        STEP_HOB_HI_SET,
        STEP_HOB_HI,
        STEP_HOB_HI_CLR,
        STEP_COUNT,
        STEP_LBA_LO,
        STEP_LBA_MID,
        STEP_LBA_HI,
        STEP_COMMAND
    } step_t;

endpackage

// ----- sv/atacmd_front.sv -----
module atacmd_front
    import atacmd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        direction,
    input  logic [1:0]  drive,
    input  logic [31:0] lba,
    input  logic [7:0]  sector_count,
    output logic        push,
    output cmd_rec_t    push_rec,
    input  logic        queue_full
);

    logic        s1_valid_reg, s1_valid_next;
    logic        s1_dir_reg, s1_dir_next;
    logic [31:0] s1_lba_reg, s1_lba_next;
    logic [7:0]  s1_cnt_reg, s1_cnt_next;
    logic [2:0]  s1_bits_reg, s1_bits_next;
    logic [56:0] s1_prod_reg, s1_prod_next;

    logic        s1_load;
    logic        accept;
    logic [3:0]  bit_lo;

    logic [22:0] q0;
    logic [22:0] quot;
    logic [28:0] q63;
    logic [28:0] rem_full;
    logic [6:0]  r0;
    logic [6:0]  rem;
    logic        fix;
    logic        ext;
    logic        chan;
    logic        slave;
    logic        has_lba;
    logic [3:0]  head;
    logic [7:0]  dev_base;

    always_comb
    begin
        push     = s1_valid_reg && !queue_full;
        s1_load  = !s1_valid_reg || push;
        in_stall = !s1_load;
        accept   = in_valid && s1_load;
    end

    // drive d occupies bits 3d..3d+2 of the table
    always_comb
    begin
        bit_lo        = {1'b0, drive, 1'b0} + {2'b00, drive};
        s1_valid_next = accept ? 1'b1 : (push ? 1'b0 : s1_valid_reg);
        s1_dir_next   = accept ? direction : s1_dir_reg;
        s1_lba_next   = accept ? lba : s1_lba_reg;
        s1_cnt_next   = accept ? sector_count : s1_cnt_reg;
        s1_bits_next  = accept ? cfg.drive_table[bit_lo +: 3] : s1_bits_reg;
        s1_prod_next  = accept ? ({29'b0, lba[27:0]} * {28'b0, CHS_RECIP}) : s1_prod_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_dir_reg  <= s1_dir_next;
        s1_lba_reg  <= s1_lba_next;
        s1_cnt_reg  <= s1_cnt_next;
        s1_bits_reg <= s1_bits_next;
        s1_prod_reg <= s1_prod_next;
    end

    // quotient estimate, then one correction step on the remainder
    always_comb
    begin
        q0       = s1_prod_reg[56:CHS_RECIP_SHIFT];
        q63      = {q0, 6'b0} - {6'b0, q0};
        rem_full = {1'b0, s1_lba_reg[27:0]} - q63;
        r0       = rem_full[6:0];
        fix      = (r0 >= CHS_SPT);
        rem      = fix ? (r0 - CHS_SPT) : r0;
        quot     = fix ? (q0 + 23'd1) : q0;
    end

    always_comb
    begin
        ext     = (s1_lba_reg[31:28] != 4'h0);
        chan    = s1_bits_reg[0];
        slave   = s1_bits_reg[1];
        has_lba = s1_bits_reg[2];

        push_rec          = '0;
        push_rec.ext      = ext;
        push_rec.cmd_base = chan ? cfg.sec_cmd_base : cfg.pri_cmd_base;
        push_rec.ctrl_addr = (chan ? cfg.sec_ctrl_base : cfg.pri_ctrl_base) + CTRL_OFFSET;
        push_rec.count    = s1_cnt_reg;
        push_rec.b3       = s1_lba_reg[31:24];

        if (ext)
        begin
            head        = 4'h0;
            dev_base    = DEVSEL_LBA;
            push_rec.b0 = s1_lba_reg[7:0];
            push_rec.b1 = s1_lba_reg[15:8];
            push_rec.b2 = s1_lba_reg[23:16];
        end
        else if (has_lba)
        begin
            head        = s1_lba_reg[27:24];
            dev_base    = DEVSEL_LBA;
            push_rec.b0 = s1_lba_reg[7:0];
            push_rec.b1 = s1_lba_reg[15:8];
            push_rec.b2 = s1_lba_reg[23:16];
        end
        else
        begin
            // track = quot, 16 heads per cylinder
            head        = quot[3:0];
            dev_base    = DEVSEL_CHS;
            push_rec.b0 = {1'b0, rem} + 8'd1;
            push_rec.b1 = quot[11:4];
            push_rec.b2 = quot[19:12];
        end

        push_rec.devsel = dev_base | {3'b000, slave, head};

        if (s1_dir_reg)
        begin
            push_rec.opcode = ext ? CMD_WRITE_EXT : CMD_WRITE;
        end
        else
        begin
            push_rec.opcode = ext ? CMD_READ_EXT : CMD_READ;
        end
    end

endmodule

// ----- sv/atacmd_queue.sv -----
module atacmd_queue
    import atacmd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  cmd_rec_t push_rec,
    output logic     full,
    input  logic     pop,
    output logic     head_valid,
    output cmd_rec_t head_rec
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_rec_t        entries_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    always_comb
    begin
        full       = (count_reg == CW'(DEPTH));
        head_valid = (count_reg != '0);
        head_rec   = entries_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

// ----- sv/atacmd_back.sv -----
module atacmd_back
    import atacmd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  cmd_rec_t    head_rec,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] io_address,
    output logic [7:0]  write_data,
    output logic        last
);

    step_t       step_reg, step_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] addr_reg, addr_next;
    logic [7:0]  data_reg, data_next;
    logic        last_reg, last_next;

    logic        load;
    logic [15:0] wr_addr;
    logic [7:0]  wr_data;
    logic        wr_last;

    assign load = head_valid && (!out_valid_reg || !out_stall);
    assign pop  = load && (step_reg == STEP_COMMAND);

    // next step
    always_comb
    begin
        step_next = step_reg;
        if (load)
        begin
            case (step_reg)
                STEP_DEVSEL:  step_next = head_rec.ext ? STEP_HOB_CNT_SET : STEP_COUNT;
                STEP_COMMAND: step_next = STEP_CTRL;
                default:      step_next = step_t'(step_reg + 5'd1);
            endcase
        end
    end

    // port write for the current step
    always_comb
    begin
        wr_last = 1'b0;
        case (step_reg)
            STEP_CTRL:
            begin
                wr_addr = head_rec.ctrl_addr;
                wr_data = CTRL_NIEN;
            end
            STEP_DEVSEL:
            begin
                wr_addr = head_rec.cmd_base + REG_DEVSEL;
                wr_data = head_rec.devsel;
            end
            STEP_HOB_CNT_SET, STEP_HOB_LO_SET, STEP_HOB_MID_SET, STEP_HOB_HI_SET:
            begin
                wr_addr = head_rec.ctrl_addr;
                wr_data = CTRL_HOB | CTRL_NIEN;
            end
            STEP_HOB_CNT_CLR, STEP_HOB_LO_CLR, STEP_HOB_MID_CLR, STEP_HOB_HI_CLR:
            begin
                wr_addr = head_rec.ctrl_addr;
                wr_data = CTRL_NIEN;
            end
            STEP_HOB_CNT:
            begin
                wr_addr = head_rec.cmd_base + REG_COUNT;
                wr_data = 8'h00;
            end
            STEP_HOB_LO:
            begin
                wr_addr = head_rec.cmd_base + REG_LBA_LO;
                wr_data = head_rec.b3;
            end
            STEP_HOB_MID:
            begin
                wr_addr = head_rec.cmd_base + REG_LBA_MID;
                wr_data = 8'h00;
            end
            STEP_HOB_HI:
            begin
                wr_addr = head_rec.cmd_base + REG_LBA_HI;
                wr_data = 8'h00;
            end
            STEP_COUNT:
            begin
                wr_addr = head_rec.cmd_base + REG_COUNT;
                wr_data = head_rec.count;
            end
            STEP_LBA_LO:
            begin
                wr_addr = head_rec.cmd_base + REG_LBA_LO;
                wr_data = head_rec.b0;
            end
            STEP_LBA_MID:
            begin
                wr_addr = head_rec.cmd_base + REG_LBA_MID;
                wr_data = head_rec.b1;
            end
            STEP_LBA_HI:
            begin
                wr_addr = head_rec.cmd_base + REG_LBA_HI;
                wr_data = head_rec.b2;
            end
            STEP_COMMAND:
            begin
                wr_addr = head_rec.cmd_base + REG_COMMAND;
                wr_data = head_rec.opcode;
                wr_last = 1'b1;
            end
            default:
            begin
                wr_addr = head_rec.ctrl_addr;
                wr_data = CTRL_NIEN;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = load ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);
        addr_next      = load ? wr_addr : addr_reg;
        data_next      = load ? wr_data : data_reg;
        last_next      = load ? wr_last : last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_CTRL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign io_address = addr_reg;
    assign write_data = data_reg;
    assign last       = last_reg;

endmodule

// ----- sv/ata_taskfile_command_issuer.sv -----
// ATA PIO task file setup: each accepted request (direction, drive, lba, sector count)
// turns into the ordered byte writes to I/O ports that program the task file and issue
// a PIO read or write, 7 writes for LBA28 or CHS and 19 for LBA48 (lba at or above 2^28),
// with last set on the command opcode write. The output sequencer produces one port
// write per cycle while out_stall is low and a command is queued, and the next command
// follows with no gap when it is already queued. A request is captured with the CHS
// reciprocal multiply, classified into the command queue and then loaded into the
// output register, where its first write is presented. The queue holds up to
// QUEUE_DEPTH resolved commands, the one being emitted included, and one more request
// can wait in the capture stage; beyond that in_stall is raised. Port and drive
// table registers are written through cfg_write_en, cfg_index and cfg_data and must
// only change while no command is in flight.
module ata_taskfile_command_issuer
    import atacmd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        direction,
    input  logic [1:0]  drive,
    input  logic [31:0] lba,
    input  logic [7:0]  sector_count,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] io_address,
    output logic [7:0]  write_data,
    output logic        last
);

    cfg_t     cfg_reg, cfg_next;
    logic     push;
    cmd_rec_t push_rec;
    logic     queue_full;
    logic     pop;
    logic     head_valid;
    cmd_rec_t head_rec;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_PRI_CMD_BASE:  cfg_next.pri_cmd_base  = cfg_data;
                CFG_PRI_CTRL_BASE: cfg_next.pri_ctrl_base = cfg_data;
                CFG_SEC_CMD_BASE:  cfg_next.sec_cmd_base  = cfg_data;
                CFG_SEC_CTRL_BASE: cfg_next.sec_ctrl_base = cfg_data;
                CFG_DRIVE_TABLE:   cfg_next.drive_table   = cfg_data[11:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pri_cmd_base  <= PRI_CMD_BASE_RST;
            cfg_reg.pri_ctrl_base <= PRI_CTRL_BASE_RST;
            cfg_reg.sec_cmd_base  <= SEC_CMD_BASE_RST;
            cfg_reg.sec_ctrl_base <= SEC_CTRL_BASE_RST;
            cfg_reg.drive_table   <= DRIVE_TABLE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    atacmd_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .direction    (direction),
        .drive        (drive),
        .lba          (lba),
        .sector_count (sector_count),
        .push         (push),
        .push_rec     (push_rec),
        .queue_full   (queue_full)
    );

    atacmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_rec   (push_rec),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_rec   (head_rec)
    );

    atacmd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_rec   (head_rec),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .io_address (io_address),
        .write_data (write_data),
        .last       (last)
    );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import atacmd_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int MAX_SHOWN    = 50;
    localparam int CHS_HEADS    = 16;
    localparam int CFG_SLOTS    = 8;

    typedef struct packed {
        logic [15:0] addr;
        logic [7:0]  data;
        logic        fin;
    } port_write_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write_en;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        direction;
    logic [1:0]  drive;
    logic [31:0] lba;
    logic [7:0]  sector_count;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] io_address;
    logic [7:0]  write_data;
    logic        last;

    // shadow of the register file as the block should hold it
    cfg_t regs;

    port_write_t pending_writes[$];

    int error_count   = 0;
    int request_count = 0;
    int write_count   = 0;
    int chs_count     = 0;
    int lba28_count   = 0;
    int lba48_count   = 0;
    int cycle_count   = 0;
    int rx_hold       = 0;
    bit tx_idle_on    = 1'b1;
    bit rx_idle_on    = 1'b1;

    ata_taskfile_command_issuer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .direction    (direction),
        .drive        (drive),
        .lba          (lba),
        .sector_count (sector_count),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .io_address   (io_address),
        .write_data   (write_data),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void push_write(input logic [15:0] addr, input logic [7:0] data,
                                       input logic fin);
        port_write_t w;
        w.addr = addr;
        w.data = data;
        w.fin  = fin;
        pending_writes.push_back(w);
    endfunction

    // high-order register write bracketed by hob set and hob clear
    function automatic void push_hob_write(input logic [15:0] ctl, input logic [15:0] addr,
                                           input logic [7:0] data);
        push_write(ctl, CTRL_HOB | CTRL_NIEN, 1'b0);
        push_write(addr, data, 1'b0);
        push_write(ctl, CTRL_NIEN, 1'b0);
    endfunction

    function automatic void build_taskfile_writes(input logic dir, input logic [1:0] drv,
                                                  input logic [31:0] addr,
                                                  input logic [7:0] cnt);
        logic [2:0]  bits;
        logic [15:0] base;
        logic [15:0] ctl;
        logic [15:0] cyl;
        logic [31:0] track;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  devsel;
        logic [7:0]  opcode;
        logic [3:0]  head;
        logic        ext;
        bits = 3'(regs.drive_table >> (3 * drv));
        base = bits[0] ? regs.sec_cmd_base : regs.pri_cmd_base;
        ctl  = 16'((bits[0] ? regs.sec_ctrl_base : regs.pri_ctrl_base) + CTRL_OFFSET);
        ext  = addr >= 32'h1000_0000;
        if (ext || bits[2])
        begin
            b0     = addr[7:0];
            b1     = addr[15:8];
            b2     = addr[23:16];
            head   = ext ? 4'h0 : addr[27:24];
            devsel = DEVSEL_LBA;
            if (ext)
                lba48_count++;
            else
                lba28_count++;
        end
        else
        begin
            track  = addr / 32'(CHS_SPT);
            cyl    = 16'(track / CHS_HEADS);
            b0     = 8'(addr % 32'(CHS_SPT) + 32'd1);
            b1     = cyl[7:0];
            b2     = cyl[15:8];
            head   = track[3:0];
            devsel = DEVSEL_CHS;
            chs_count++;
        end
        if (dir)
            opcode = ext ? CMD_WRITE_EXT : CMD_WRITE;
        else
            opcode = ext ? CMD_READ_EXT : CMD_READ;

        push_write(ctl, CTRL_NIEN, 1'b0);
        push_write(16'(base + REG_DEVSEL), devsel | {3'b000, bits[1], head}, 1'b0);
        if (ext)
        begin
            push_hob_write(ctl, 16'(base + REG_COUNT), 8'h00);
            push_hob_write(ctl, 16'(base + REG_LBA_LO), addr[31:24]);
            push_hob_write(ctl, 16'(base + REG_LBA_MID), 8'h00);
            push_hob_write(ctl, 16'(base + REG_LBA_HI), 8'h00);
        end
        push_write(16'(base + REG_COUNT), cnt, 1'b0);
        push_write(16'(base + REG_LBA_LO), b0, 1'b0);
        push_write(16'(base + REG_LBA_MID), b1, 1'b0);
        push_write(16'(base + REG_LBA_HI), b2, 1'b0);
        push_write(16'(base + REG_COMMAND), opcode, 1'b1);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (error_count < MAX_SHOWN)
            $display("mismatch at port write %0d: %s expected %h got %h",
                     write_count, what, want, got);
        error_count++;
    endtask

    task automatic send_request(input logic dir, input logic [1:0] drv,
                                input logic [31:0] addr, input logic [7:0] cnt);
        int gap;
        gap = (tx_idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        direction    <= dir;
        drive        <= drv;
        lba          <= addr;
        sector_count <= cnt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        build_taskfile_writes(dir, drv, addr, cnt);
        request_count++;
    endtask

    task automatic send_random_request();
        logic [31:0] addr;
        case ($urandom_range(0, 5))
            0:       addr = $urandom_range(0, 4 * 1008);
            1, 2:    addr = {4'h0, 28'($urandom)};
            // straddle the lba48 threshold
            3:       addr = 32'h1000_0000 + $urandom_range(0, 3) - 32'd2;
            default: addr = $urandom;
        endcase
        send_request(1'($urandom), 2'($urandom), addr, 8'($urandom));
    endtask

    // always returns just after a rising edge, with the input side idle
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_writes.size() != 0);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= index;
        cfg_data     <= value;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        case (index)
            CFG_PRI_CMD_BASE:  regs.pri_cmd_base  = value;
            CFG_PRI_CTRL_BASE: regs.pri_ctrl_base = value;
            CFG_SEC_CMD_BASE:  regs.sec_cmd_base  = value;
            CFG_SEC_CTRL_BASE: regs.sec_ctrl_base = value;
            CFG_DRIVE_TABLE:   regs.drive_table   = value[11:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [15:0] pcmd, input logic [15:0] pctrl,
                             input logic [15:0] scmd, input logic [15:0] sctrl,
                             input logic [15:0] tbl);
        drain_results();
        write_reg(CFG_PRI_CMD_BASE, pcmd);
        write_reg(CFG_PRI_CTRL_BASE, pctrl);
        write_reg(CFG_SEC_CMD_BASE, scmd);
        write_reg(CFG_SEC_CTRL_BASE, sctrl);
        write_reg(CFG_DRIVE_TABLE, tbl);
    endtask

    // reset table: every drive is a chs primary master
    task automatic test_reset_defaults();
        send_request(1'b0, 2'd0, 32'd0, 8'd0);
        send_request(1'b1, 2'd3, 32'd62, 8'd255);
        send_request(1'b0, 2'd1, 32'd63, 8'd1);
        send_request(1'b1, 2'd2, 32'd1007, 8'd8);
        send_request(1'b0, 2'd0, 32'd1008, 8'h80);
        // cylinder no longer fits in 16 bits
        send_request(1'b0, 2'd0, 32'h0FFF_FFFF, 8'hFF);
        send_request(1'b1, 2'd1, 32'h1000_0000, 8'h55);
        send_request(1'b0, 2'd2, 32'hFFFF_FFFF, 8'h00);
    endtask

    task automatic test_directed_modes();
        drain_results();
        // d0 chs primary master, d1 lba secondary slave, d2 lba primary slave,
        // d3 chs secondary master; upper bits must be dropped
        write_reg(CFG_DRIVE_TABLE, 16'hF3B8);
        for (int idx = CFG_DRIVE_TABLE + 1; idx < CFG_SLOTS; idx++)
            write_reg(3'(idx), 16'hFFFF);
        send_request(1'b0, 2'd1, 32'h0ABC_DEF1, 8'h12);
        send_request(1'b1, 2'd1, 32'h0FFF_FFFF, 8'hFF);
        send_request(1'b1, 2'd2, 32'h0000_0000, 8'h01);
        send_request(1'b0, 2'd3, 32'h0012_3456, 8'hAA);
        send_request(1'b1, 2'd0, 32'h1000_0000, 8'h00);
        send_request(1'b0, 2'd3, 32'hFEDC_BA98, 8'h7F);
        // every base at the top so the offsets wrap
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(1'b0, 2'd0, 32'h0000_FFFF, 8'h10);
        send_request(1'b1, 2'd3, 32'h8000_0000, 8'hFE);
        configure(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_request(1'b0, 2'd2, 32'h00AB_CDEF, 8'h03);
        send_request(1'b1, 2'd1, 32'hFFFF_FFFF, 8'hC3);
    endtask

    task automatic test_random_traffic();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: configure(PRI_CMD_BASE_RST, PRI_CTRL_BASE_RST, SEC_CMD_BASE_RST,
                             SEC_CTRL_BASE_RST, 16'($urandom));
                1: configure(16'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom));
                2: configure(16'hFFFE, 16'hFFFD, 16'h0001, 16'hFFFF, 16'h0FFF);
                default: configure(16'($urandom), 16'h0000, 16'h0000, 16'($urandom),
                                   16'($urandom));
            endcase
            repeat (80) send_random_request();
        end
    endtask

    // output held off long enough that the input side has to stall
    task automatic test_long_stall();
        drain_results();
        rx_hold = 200;
        repeat (12) send_random_request();
    endtask

    task automatic test_drain_pause();
        repeat (10) send_random_request();
        drain_results();
        repeat (10) send_random_request();
    endtask

    task automatic test_steady_stream();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        configure(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom));
        repeat (40) send_random_request();
    endtask

    // receiver side: random stall bursts plus an optional long hold
    initial
    begin
        int burst;
        burst     = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                rx_hold--;
                out_stall <= 1'b1;
            end
            else if (burst > 0)
            begin
                burst--;
                out_stall <= 1'b1;
            end
            else if (rx_idle_on && $urandom_range(0, 7) == 0)
            begin
                burst = $urandom_range(0, 5);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // one word per accepted handshake, checked against the oldest expectation
    initial
    begin
        port_write_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_writes.size() == 0)
                    report_mismatch("unexpected word, io_address", 32'd0, io_address);
                else
                begin
                    want = pending_writes.pop_front();
                    if (io_address !== want.addr)
                        report_mismatch("io_address", want.addr, io_address);
                    if (write_data !== want.data)
                        report_mismatch("write_data", want.data, write_data);
                    if (last !== want.fin)
                        report_mismatch("last", want.fin, last);
                end
                write_count++;
            end
        end
    end

    initial
    begin
        while (cycle_count <= LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout with %0d port writes still expected", pending_writes.size());
        $display("status: fail");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = CFG_PRI_CMD_BASE;
        cfg_data     = 16'h0000;
        in_valid     = 1'b0;
        direction    = 1'b0;
        drive        = 2'd0;
        lba          = 32'd0;
        sector_count = 8'd0;
        regs = {PRI_CMD_BASE_RST, PRI_CTRL_BASE_RST, SEC_CMD_BASE_RST,
                SEC_CTRL_BASE_RST, DRIVE_TABLE_RST};
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_directed_modes();
        test_random_traffic();
        test_long_stall();
        test_drain_pause();
        test_steady_stream();

        drain_results();
        repeat (20) @(posedge clk);

        $display("sent %0d requests: %0d chs, %0d lba28, %0d lba48, over several base setups",
                 request_count, chs_count, lba28_count, lba48_count);
        $display("checked %0d port writes under output stalls and input backpressure",
                 write_count);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
